FILE: rtl/core/pcx_pkg.sv
// shared types, constants and helpers of the pcx run-length image decoder
// no dependencies; imported by every module of the block
package pcx_pkg;

    localparam int MAX_DIMENSION   = 4096;
    localparam int LINE_LIMIT      = 8192;
    localparam int PALETTE_SIZE    = 256;
    localparam int PAL_W           = $clog2(PALETTE_SIZE);
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] RUN_THRESHOLD = 8'd192;
    localparam logic [7:0] MARKER_BYTE   = 8'h0C;
    localparam logic [3:0] BPP_SUPPORTED = 4'd8;

    typedef enum logic [2:0] {
        PH_PIXEL,
        PH_MARKER,
        PH_PALETTE,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_COLOR = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic {
        ERR_BAD_DEPTH = 1'b0,
        ERR_NO_MARKER = 1'b1
    } t_err;

    typedef enum logic [1:0] {
        CFG_BYTES_PER_LINE = 2'd0,
        CFG_IMAGE_WIDTH    = 2'd1,
        CFG_IMAGE_HEIGHT   = 2'd2,
        CFG_BITS_PER_PIXEL = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [13:0] bytes_per_line;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [3:0]  bits_per_pixel;
    } t_cfg;

    // one classified file byte as it waits in the queue
    typedef struct packed {
        logic [7:0] file_byte;
        logic       is_run;
        logic       is_marker;
        logic [4:0] color;
    } t_item;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  palette_index;
        logic [14:0] value;
        t_err        error_code;
        logic        last;
    } t_result;

    // min(x + 4, 255) >> 3
    function automatic logic [4:0] scale_color(input logic [7:0] x);
        logic [8:0] s;
        s = {1'b0, x} + 9'd4;
        if (s[8]) begin
            return 5'd31;
        end
        return s[7:3];
    endfunction

endpackage

FILE: rtl/core/pcx_front.sv
// front end: accepts file bytes, classifies them and queues them for the back end
// depends on pcx_pkg
module pcx_front
    import pcx_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_byte_valid,
    output logic  o_byte_ready,
    input  logic [7:0] i_byte,
    output logic  o_q_valid,
    output t_item o_q_item,
    input  logic  i_q_pop
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           push;
    t_item          cls;

    always_comb begin
        cls.file_byte = i_byte;
        cls.is_run    = (i_byte >= RUN_THRESHOLD);
        cls.is_marker = (i_byte == MARKER_BYTE);
        cls.color     = scale_color(i_byte);
    end

    assign o_byte_ready = (r_count != CW'(QUEUE_DEPTH));
    assign push         = i_byte_valid && o_byte_ready;
    assign o_q_valid    = (r_count != '0);
    assign o_q_item     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_q_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push && !i_q_pop) begin
            n_count = r_count + CW'(1);
        end else if (!push && i_q_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    a_full_ptrs_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(QUEUE_DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue full but pointers differ");

endmodule

FILE: rtl/core/pcx_back.sv
// back end: scan line bookkeeping, run expansion, marker check and palette packing
// depends on pcx_pkg; fed by pcx_front through its queue
module pcx_back
    import pcx_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output logic    o_q_pop,
    output logic    o_out_valid,
    output t_result o_out,
    input  logic    i_out_ready
);

    t_phase          r_phase, n_phase;
    logic [12:0]     r_pos, n_pos;
    logic [12:0]     r_row, n_row;
    logic            r_awaiting, n_awaiting;
    logic [5:0]      r_pending, n_pending;
    logic [5:0]      r_run_left, n_run_left;
    logic [7:0]      r_run_val, n_run_val;
    logic [1:0]      r_step, n_step;
    logic [PAL_W-1:0] r_count, n_count;
    logic [4:0]      r_red, n_red;
    logic [4:0]      r_green, n_green;
    logic            r_out_valid;
    t_result         r_out, n_res;
    logic            n_load;

    logic [12:0] eff_w, eff_h;
    logic [13:0] eff_bpl;
    logic        can_emit, run_active;

    t_phase      s_phase;
    logic [12:0] s_pos, s_row;
    logic        s_await;

    logic [12:0] base_pos, base_row;
    logic [7:0]  base_val;
    logic [13:0] pos_inc;
    logic [12:0] row_inc;
    logic        px_emit, px_line_end, px_tail, px_marker;
    logic [12:0] px_pos, px_row;
    t_result     px_res;

    always_comb begin
        eff_w   = (i_cfg.image_width > 13'(MAX_DIMENSION)) ? 13'(MAX_DIMENSION)
                                                         : i_cfg.image_width;
        eff_h   = (i_cfg.image_height > 13'(MAX_DIMENSION)) ? 13'(MAX_DIMENSION)
                                                          : i_cfg.image_height;
        eff_bpl = (i_cfg.bytes_per_line > 14'(LINE_LIMIT)) ? 14'(LINE_LIMIT)
                                                         : i_cfg.bytes_per_line;
    end

    assign can_emit   = !r_out_valid || i_out_ready;
    assign run_active = (r_run_left != '0);

    // line and row bookkeeping that precedes each byte
    always_comb begin
        s_phase = r_phase;
        s_pos   = r_pos;
        s_row   = r_row;
        s_await = r_awaiting;
        if (r_phase == PH_PIXEL) begin
            if (r_row >= eff_h || eff_bpl == '0) begin
                s_phase = PH_MARKER;
                s_await = 1'b0;
            end else if ({1'b0, r_pos} >= eff_bpl) begin
                s_pos = '0;
                s_row = r_row + 13'd1;
                if (s_row >= eff_h) begin
                    s_phase = PH_MARKER;
                    s_await = 1'b0;
                end
            end
        end
    end

    // one pixel position, shared by literals and run steps
    always_comb begin
        base_pos    = run_active ? r_pos : s_pos;
        base_row    = run_active ? r_row : s_row;
        base_val    = run_active ? r_run_val : i_q_item.file_byte;
        pos_inc     = {1'b0, base_pos} + 14'd1;
        row_inc     = base_row + 13'd1;
        px_emit     = (base_pos < eff_w);
        px_line_end = (pos_inc >= eff_bpl);
        px_tail     = (pos_inc >= {1'b0, eff_w});
        px_marker   = px_line_end && (row_inc >= eff_h);
        px_pos      = px_line_end ? '0 : pos_inc[12:0];
        px_row      = px_line_end ? row_inc : base_row;
        px_res.kind          = KIND_PIXEL;
        px_res.column        = base_pos[11:0];
        px_res.row           = base_row[11:0];
        px_res.palette_index = '0;
        px_res.value         = {7'd0, base_val};
        px_res.error_code    = ERR_BAD_DEPTH;
        px_res.last          = 1'b1;
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_row      = r_row;
        n_awaiting = r_awaiting;
        n_pending  = r_pending;
        n_run_left = r_run_left;
        n_run_val  = r_run_val;
        n_step     = r_step;
        n_count    = r_count;
        n_red      = r_red;
        n_green    = r_green;
        n_load     = 1'b0;
        o_q_pop    = 1'b0;
        n_res.kind          = KIND_ERROR;
        n_res.column        = '0;
        n_res.row           = '0;
        n_res.palette_index = '0;
        n_res.value         = '0;
        n_res.error_code    = ERR_BAD_DEPTH;
        n_res.last          = 1'b1;

        if (run_active) begin
            // padding positions advance without needing the output
            if (!px_emit || can_emit) begin
                n_pos      = px_pos;
                n_row      = px_row;
                n_run_left = px_line_end ? '0 : r_run_left - 6'd1;
                if (px_marker) begin
                    n_phase = PH_MARKER;
                end
                if (px_emit) begin
                    n_load      = 1'b1;
                    n_res       = px_res;
                    n_res.last  = (r_run_left == 6'd1) || px_line_end || px_tail;
                end
            end
        end else if (i_q_valid && can_emit) begin
            o_q_pop = 1'b1;
            if (r_phase != PH_DONE && r_phase != PH_ERROR) begin
                if (i_cfg.bits_per_pixel != BPP_SUPPORTED) begin
                    n_load           = 1'b1;
                    n_res.error_code = ERR_BAD_DEPTH;
                    n_phase          = PH_ERROR;
                end else begin
                    n_phase    = s_phase;
                    n_pos      = s_pos;
                    n_row      = s_row;
                    n_awaiting = s_await;
                    case (s_phase)
                        PH_PIXEL: begin
                            if (s_await) begin
                                n_awaiting = 1'b0;
                                n_run_left = r_pending;
                                n_run_val  = i_q_item.file_byte;
                            end else if (i_q_item.is_run) begin
                                n_pending  = i_q_item.file_byte[5:0];
                                n_awaiting = 1'b1;
                            end else begin
                                n_pos = px_pos;
                                n_row = px_row;
                                if (px_marker) begin
                                    n_phase = PH_MARKER;
                                end
                                if (px_emit) begin
                                    n_load = 1'b1;
                                    n_res  = px_res;
                                end
                            end
                        end
                        PH_MARKER: begin
                            if (i_q_item.is_marker) begin
                                n_phase = PH_PALETTE;
                                n_step  = '0;
                                n_count = '0;
                            end else begin
                                n_load           = 1'b1;
                                n_res.error_code = ERR_NO_MARKER;
                                n_phase          = PH_ERROR;
                            end
                        end
                        PH_PALETTE: begin
                            case (r_step)
                                2'd0: begin
                                    n_red  = i_q_item.color;
                                    n_step = 2'd1;
                                end
                                2'd1: begin
                                    n_green = i_q_item.color;
                                    n_step  = 2'd2;
                                end
                                default: begin
                                    n_load              = 1'b1;
                                    n_res.kind          = KIND_COLOR;
                                    n_res.palette_index = 8'(r_count);
                                    n_res.value         = {i_q_item.color, r_green, r_red};
                                    n_step              = '0;
                                    n_count             = r_count + PAL_W'(1);
                                    if (r_count == PAL_W'(PALETTE_SIZE - 1)) begin
                                        n_phase = PH_DONE;
                                    end
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PIXEL;
            r_pos       <= '0;
            r_row       <= '0;
            r_awaiting  <= 1'b0;
            r_pending   <= '0;
            r_run_left  <= '0;
            r_step      <= '0;
            r_count     <= '0;
            r_red       <= '0;
            r_green     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_row      <= n_row;
            r_awaiting <= n_awaiting;
            r_pending  <= n_pending;
            r_run_left <= n_run_left;
            r_step     <= n_step;
            r_count    <= n_count;
            r_red      <= n_red;
            r_green    <= n_green;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run_val <= n_run_val;
        if (n_load) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_run_in_pixel_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_left != '0) |-> (r_phase == PH_PIXEL && !r_awaiting))
        else $error("run active outside pixel phase or with a pending header");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ERROR) |=> (r_phase == PH_ERROR))
        else $error("left error phase without reset");

    a_done_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> (r_count == '0 && r_step == '0))
        else $error("palette done with partial entry");

endmodule

FILE: rtl/core/pcx_rle_image_decoder_top.sv
// top level of the 8-bit pcx run-length image decoder: header registers and stream ports
// depends on pcx_pkg, pcx_front and pcx_back
//
// Usage: file bytes that follow the pcx header enter on the s_axis channel, one byte
// per transfer. Header values are written beforehand on the cfg channel (index 0 bytes
// per line, 1 image width, 2 image height, 3 bits per pixel), only while no result is
// outstanding. Results leave on m_axis: pixels, palette colors and error reports, with
// tlast on the last result caused by a byte.
// With an idle back end a byte leaves the input queue and its result is loaded into the output
// register in the same cycle; the first pixel of a run is produced from the run count and value
// registers that the value byte loads as it leaves the queue.
// Throughput: literal, marker and palette bytes take one cycle each while the output is
// not stalled. A run value byte then holds the back end for one cycle per pixel position of
// the run while the output is not stalled, padding positions included, up to 63 positions
// or the end of the scan line; the input queue keeps accepting bytes meanwhile until it is full.
// Reset returns the configuration to 1,1,1,8 and the decoder to the start of pixel data.
// When the receiver stalls, the output register holds its result, the back end stops except
// for padding positions of a run, and s_axis_tready falls once the input queue is full.
module pcx_rle_image_decoder_top
    import pcx_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [11:0] column, [23:12] row, [31:24] palette_index,
                                        // [46:32] value, [47] error_code
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    q_valid, q_pop;
    t_item   q_item;
    t_result out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_line <= 14'd1;
            r_cfg.image_width    <= 13'd1;
            r_cfg.image_height   <= 13'd1;
            r_cfg.bits_per_pixel <= BPP_SUPPORTED;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_BYTES_PER_LINE: r_cfg.bytes_per_line <= i_cfg_data;
                CFG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_data[12:0];
                CFG_IMAGE_HEIGHT:   r_cfg.image_height   <= i_cfg_data[12:0];
                CFG_BITS_PER_PIXEL: r_cfg.bits_per_pixel <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    pcx_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (s_axis_tvalid),
        .o_byte_ready (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .o_q_valid    (q_valid),
        .o_q_item     (q_item),
        .i_q_pop      (q_pop)
    );

    pcx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (m_axis_tvalid),
        .o_out       (out),
        .i_out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {out.error_code, out.value, out.palette_index, out.row, out.column};
    assign m_axis_tuser = out.kind;
    assign m_axis_tlast = out.last;

endmodule

FILE: tb/sv/tb_pcx_rle_image_decoder_top.sv
// self-checking testbench for pcx_rle_image_decoder_top: directed table, random scan lines
// and one randomly chosen ending (bad depth, missing marker or full palette)
// depends on pcx_pkg and the rtl of the decoder
module tb_pcx_rle_image_decoder_top
    import pcx_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 200;
    // worst back end work per queued byte is one run of 63 positions
    localparam int SETTLE_CYCLES = (QUEUE_DEPTH_DEF + 2) * 64;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0]  data;
        logic        typed;      // expectation written below instead of predicted
        logic        one_pixel;  // typed row gives one pixel with the byte as its value
        logic [11:0] col;
        logic [11:0] row;
    } t_stim;

    localparam int DIR_LEN   = 22;
    localparam int DIR_SPLIT = 18;
    // rows before the split run with 8 bytes per line and 5 kept pixels,
    // the rest with one byte per line
    localparam t_stim DIRECTED [0:DIR_LEN-1] = '{
        '{8'h00, 1'b1, 1'b1, 12'd0, 12'd0},
        '{8'hBF, 1'b1, 1'b1, 12'd1, 12'd0},
        '{8'hC0, 1'b1, 1'b0, 12'd0, 12'd0},   // zero run length
        '{8'h55, 1'b1, 1'b0, 12'd0, 12'd0},
        '{8'hFF, 1'b0, 1'b0, 12'd0, 12'd0},   // longest run, clipped at end of line
        '{8'hAA, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'hC3, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'hFE, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h80, 1'b1, 1'b1, 12'd3, 12'd1},
        '{8'h01, 1'b1, 1'b1, 12'd4, 12'd1},
        '{8'h7F, 1'b1, 1'b0, 12'd0, 12'd0},   // padding columns are dropped
        '{8'h40, 1'b1, 1'b0, 12'd0, 12'd0},
        '{8'hC1, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h00, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'hC2, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'hC8, 1'b0, 1'b0, 12'd0, 12'd0},   // run value above the threshold
        '{8'hC0, 1'b1, 1'b0, 12'd0, 12'd0},
        '{8'hFF, 1'b1, 1'b0, 12'd0, 12'd0},
        '{8'h33, 1'b1, 1'b1, 12'd0, 12'd3},   // shorter line ends the current one first
        '{8'hC5, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'h77, 1'b0, 1'b0, 12'd0, 12'd0},
        '{8'hBF, 1'b1, 1'b1, 12'd0, 12'd5}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [13:0] i_cfg_data = 14'd0;

    pcx_rle_image_decoder_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #12ms;
        $display("tb_pcx_rle_image_decoder_top NOT OK");
        $finish;
    end

    // shadow copy of the decoder state and header registers
    int      hdr_bpl = 1;
    int      hdr_width = 1;
    int      hdr_height = 1;
    int      hdr_bpp = 8;
    t_phase  ph = PH_PIXEL;
    int      line_pos = 0;
    int      cur_row = 0;
    bit      await_val = 1'b0;
    int      run_len = 0;
    int      rgb_step = 0;
    int      pal_count = 0;
    logic [4:0] red_q = 5'd0;
    logic [4:0] green_q = 5'd0;

    t_result step_out[$];
    t_result expected_q[$];
    int      mismatches = 0;
    int      send_idle_pct = 19;
    int      recv_idle_pct = 84;

    function automatic int line_len();
        return (hdr_bpl > LINE_LIMIT) ? LINE_LIMIT : hdr_bpl;
    endfunction

    function automatic int clamp_dim(input int v);
        return (v > MAX_DIMENSION) ? MAX_DIMENSION : v;
    endfunction

    function automatic logic [4:0] to_rgb5(input logic [7:0] x);
        int s;
        s = x + 4;
        if (s > 255) begin
            s = 255;
        end
        return 5'(s >> 3);
    endfunction

    function automatic void emit(input t_kind k, input int col, input int rw, input int idx,
                                 input int val, input t_err e);
        t_result r;
        r.kind          = k;
        r.column        = col[11:0];
        r.row           = rw[11:0];
        r.palette_index = idx[7:0];
        r.value         = val[14:0];
        r.error_code    = e;
        r.last          = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void enter_marker();
        ph = PH_MARKER;
        await_val = 1'b0;
    endfunction

    function automatic void next_line();
        line_pos = 0;
        cur_row++;
        if (cur_row >= clamp_dim(hdr_height)) begin
            enter_marker();
        end
    endfunction

    // returns 1 when the pixel closed the scan line
    function automatic bit put_pixel(input logic [7:0] v);
        if (line_pos < clamp_dim(hdr_width)) begin
            emit(KIND_PIXEL, line_pos, cur_row, 0, v, ERR_BAD_DEPTH);
        end
        line_pos++;
        if (line_pos >= line_len()) begin
            next_line();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void load_reg(input t_cfg_reg idx, input logic [13:0] val);
        case (idx)
            CFG_BYTES_PER_LINE: hdr_bpl    = val;
            CFG_IMAGE_WIDTH:    hdr_width  = val[12:0];
            CFG_IMAGE_HEIGHT:   hdr_height = val[12:0];
            default:            hdr_bpp    = val[3:0];
        endcase
    endfunction

    // results caused by one file byte land in step_out
    function automatic void decode_byte(input logic [7:0] b);
        t_result r;
        logic [4:0] c;
        int i;
        step_out.delete();
        if (ph != PH_DONE && ph != PH_ERROR) begin
            if (hdr_bpp != BPP_SUPPORTED) begin
                emit(KIND_ERROR, 0, 0, 0, 0, ERR_BAD_DEPTH);
                ph = PH_ERROR;
            end else begin
                if (ph == PH_PIXEL) begin
                    if (cur_row >= clamp_dim(hdr_height) || line_len() == 0) begin
                        enter_marker();
                    end else if (line_pos >= line_len()) begin
                        next_line();
                    end
                end
                if (ph == PH_PIXEL) begin
                    if (await_val) begin
                        await_val = 1'b0;
                        for (i = 0; i < run_len; i++) begin
                            if (put_pixel(b)) begin
                                break;
                            end
                        end
                    end else if (b >= RUN_THRESHOLD) begin
                        run_len   = b - RUN_THRESHOLD;
                        await_val = 1'b1;
                    end else begin
                        void'(put_pixel(b));
                    end
                end else if (ph == PH_MARKER) begin
                    if (b == MARKER_BYTE) begin
                        ph        = PH_PALETTE;
                        rgb_step  = 0;
                        pal_count = 0;
                    end else begin
                        emit(KIND_ERROR, 0, 0, 0, 0, ERR_NO_MARKER);
                        ph = PH_ERROR;
                    end
                end else begin
                    c = to_rgb5(b);
                    if (rgb_step == 0) begin
                        red_q    = c;
                        rgb_step = 1;
                    end else if (rgb_step == 1) begin
                        green_q  = c;
                        rgb_step = 2;
                    end else begin
                        emit(KIND_COLOR, 0, 0, pal_count, {c, green_q, red_q}, ERR_BAD_DEPTH);
                        rgb_step  = 0;
                        pal_count = (pal_count + 1) % PALETTE_SIZE;
                        if (pal_count == 0) begin
                            ph = PH_DONE;
                        end
                    end
                end
            end
        end
        if (step_out.size() != 0) begin
            r = step_out[step_out.size() - 1];
            r.last = 1'b1;
            step_out[step_out.size() - 1] = r;
        end
    endfunction

    function automatic string show(input t_result r);
        return $sformatf("kind %0d col %0d row %0d index %0d value %h err %0d last %0d",
                         r.kind, r.column, r.row, r.palette_index, r.value, r.error_code,
                         r.last);
    endfunction

    // one byte transfer; tvalid stays high afterwards so back-to-back bytes need no toggle
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_byte(b);
        decode_byte(b);
        foreach (step_out[k]) begin
            expected_q.push_back(step_out[k]);
        end
    endtask

    // caller lowers i_cfg_valid once the group of writes is done
    task automatic write_reg(input t_cfg_reg idx, input int val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[13:0];
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        load_reg(idx, val[13:0]);
    endtask

    task automatic write_geometry(input int bpl, input int wid, input int hgt);
        write_reg(CFG_BYTES_PER_LINE, bpl);
        write_reg(CFG_IMAGE_WIDTH, wid);
        write_reg(CFG_IMAGE_HEIGHT, hgt);
    endtask

    // drain every expected result, then let queued bytes that give no result finish
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind          = t_kind'(m_axis_tuser);
            got.column        = m_axis_tdata[11:0];
            got.row           = m_axis_tdata[23:12];
            got.palette_index = m_axis_tdata[31:24];
            got.value         = m_axis_tdata[46:32];
            got.error_code    = t_err'(m_axis_tdata[47]);
            got.last          = m_axis_tlast;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: %s", show(got));
                end
            end else begin
                want = expected_q.pop_front();
                if (got.kind !== want.kind || got.column !== want.column
                        || got.row !== want.row || got.palette_index !== want.palette_index
                        || got.value !== want.value || got.error_code !== want.error_code
                        || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result mismatch\n  expected: %s\n  actual:   %s",
                                 show(want), show(got));
                    end
                end
            end
        end
    end

    initial begin
        t_result    r;
        t_stim      d;
        logic [7:0] b;
        int random_items;
        int bpl;
        int wid;
        int hgt;
        int n;
        int pick;
        int ending;
        int way;
        int bpp;

        random_items = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // depth register walks through its extremes before any byte arrives
        write_geometry(8, 5, 8191);
        write_reg(CFG_BITS_PER_PIXEL, 7);
        write_reg(CFG_BITS_PER_PIXEL, 15);
        write_reg(CFG_BITS_PER_PIXEL, 0);
        write_reg(CFG_BITS_PER_PIXEL, BPP_SUPPORTED);
        i_cfg_valid <= 1'b0;

        for (int i = 0; i < DIR_LEN; i++) begin
            d = DIRECTED[i];
            if (i == DIR_SPLIT) begin
                wait_idle();
                write_geometry(1, 8191, 8191);
                i_cfg_valid <= 1'b0;
            end
            if (!d.typed) begin
                feed_byte(d.data);
            end else begin
                send_byte(d.data);
                decode_byte(d.data);   // keeps the shadow state in step
                if (d.one_pixel) begin
                    r = '{KIND_PIXEL, d.col, d.row, 8'd0, {7'd0, d.data}, ERR_BAD_DEPTH, 1'b1};
                    expected_q.push_back(r);
                end
            end
        end

        // random scan lines, new geometry per stretch
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= RANDOM_ITEMS / 2) begin
                send_idle_pct = 84;
                recv_idle_pct = 19;
            end
            wait_idle();
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 2))
                    0:       bpl = 16383;
                    1:       bpl = LINE_LIMIT;
                    default: bpl = $urandom_range(4097, 8191);
                endcase
                wid = $urandom_range(0, 1) ? 8191 : $urandom_range(1, MAX_DIMENSION);
            end else begin
                bpl = $urandom_range(1, 24);
                wid = $urandom_range(0, bpl + 3);
            end
            hgt = $urandom_range(0, 1) ? 8191 : $urandom_range(2048, 8190);
            write_geometry(bpl, wid, hgt);
            i_cfg_valid <= 1'b0;
            n = $urandom_range(8, 30);
            repeat (n) begin
                if ($urandom_range(0, 24) == 0) begin
                    wait_idle();
                end
                pick = $urandom_range(0, 9);
                if (pick < 6) begin
                    feed_byte(8'($urandom_range(0, 191)));
                    random_items++;
                end else if (pick < 9) begin
                    feed_byte(8'($urandom_range(192, 255)));
                    feed_byte(8'($urandom()));
                    random_items += 2;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       b = 8'h00;
                        1:       b = 8'hBF;
                        2:       b = RUN_THRESHOLD;
                        default: b = 8'hFF;
                    endcase
                    feed_byte(b);
                    random_items++;
                end
            end
        end

        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        ending = $urandom_range(0, 3);
        if (ending == 0) begin
            bpp = $urandom_range(0, 15);
            if (bpp == BPP_SUPPORTED) begin
                bpp = 9;
            end
            write_reg(CFG_BITS_PER_PIXEL, bpp);
            i_cfg_valid <= 1'b0;
        end else begin
            way = $urandom_range(0, 3);
            if (way == 3) begin
                // run out the rows naturally
                write_reg(CFG_IMAGE_HEIGHT, cur_row + 1);
                i_cfg_valid <= 1'b0;
                while (ph == PH_PIXEL) begin
                    feed_byte(await_val ? 8'($urandom()) : 8'hFF);
                end
            end else begin
                if ($urandom_range(0, 1)) begin
                    // this awaited run value gets dropped
                    feed_byte(8'($urandom_range(192, 255)));
                    wait_idle();
                end
                case (way)
                    0:       write_reg(CFG_IMAGE_HEIGHT, 0);
                    1:       write_reg(CFG_BYTES_PER_LINE, 0);
                    default: write_reg(CFG_IMAGE_HEIGHT, 1);
                endcase
                i_cfg_valid <= 1'b0;
            end
            if (ending == 1) begin
                b = 8'($urandom());
                if (b == MARKER_BYTE) begin
                    b = 8'h0D;
                end
                feed_byte(b);
            end else begin
                feed_byte(MARKER_BYTE);
                for (int k = 0; k < 3 * PALETTE_SIZE; k++) begin
                    case (k)
                        0:       b = 8'h00;
                        1:       b = 8'h03;
                        2:       b = 8'h04;
                        3:       b = 8'hFB;
                        4:       b = 8'hFC;
                        5:       b = 8'hFF;
                        default: b = 8'($urandom());
                    endcase
                    feed_byte(b);
                end
            end
        end
        // nothing after completion or an error may produce a result
        repeat (4) feed_byte(8'($urandom()));

        wait_idle();
        if (mismatches == 0) begin
            $display("tb_pcx_rle_image_decoder_top OK");
        end else begin
            $display("tb_pcx_rle_image_decoder_top NOT OK");
        end
        $finish;
    end

endmodule
